/* hdl/dwmd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwmd_pkg
// Shared types and constants of the distinct window marker detector.
// ----------------------------------------------------------------------------
package dwmd_pkg;

   localparam int unsigned SYM_BITS       = 8;
   localparam int unsigned SYM_VALUES     = 1 << SYM_BITS;
   localparam int unsigned POS_BITS       = 16;
   localparam logic [POS_BITS-1:0] POS_MAX = '1;

   localparam int unsigned WINDOW_MAX_DEF = 16;
   localparam int unsigned COUNT_BITS_DEF = 16;

   // register file
   localparam int unsigned WL_BITS        = 5;
   localparam logic [WL_BITS-1:0] WL_RESET = 5'd14;
   localparam int unsigned DATA_BITS      = 32;
   localparam int unsigned ADDR_BITS      = 3;
   localparam int unsigned ADDR_LSB       = 2;
   localparam logic REG_WINDOW_LENGTH     = 1'b0;

   // control between the lookup stage and the scan stage
   typedef struct packed {
      logic valid;
      logic new_line;
      logic hit;
   } stage_type;

endpackage

/* hdl/dwmd_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwmd_req_if
// Input channel: one byte of the stream per beat, with a start-of-line flag.
// ----------------------------------------------------------------------------
interface dwmd_req_if;
   logic                          valid;
   logic                          ready;
   logic [dwmd_pkg::SYM_BITS-1:0] symbol;
   logic                          new_line;

   modport source (output valid, output symbol, output new_line, input ready);
   modport sink   (input valid, input symbol, input new_line, output ready);
endinterface

/* hdl/dwmd_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwmd_rsp_if
// Result channel: marker flag and position in line, one beat per input beat.
// ----------------------------------------------------------------------------
interface dwmd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          marker_found;
   logic [dwmd_pkg::POS_BITS-1:0] marker_position;

   modport source (output valid, output marker_found, output marker_position,
                   input ready);
   modport sink   (input valid, input marker_found, input marker_position,
                   output ready);
endinterface

/* hdl/distinct_window_marker_detector_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distinct_window_marker_detector_unit
// Flags the first byte of each line where the last window_length bytes, held
// to 2..WINDOW_MAX, all differ; reports every byte's 1-based line position.
//
//   port group  direction  beat contents
//   req_bus     in         symbol, new_line
//   rsp_bus     out        marker_found, marker_position (one per req beat)
//   apb (p*)    in/out     window_length at byte address 0
//
// One byte per cycle while results are taken; a result passes through the
// last-seen table read, then the run update into the result register.
// The last-seen table is a 256-entry memory read and rewritten on each beat,
// so its single port sets the rate. Reset clears control state only; the
// table needs no clearing pass, so input is taken right after reset.
// A stalled result holds the scan stage; the input side keeps taking beats
// while the scan stage is empty or moving.
// ----------------------------------------------------------------------------
module distinct_window_marker_detector_unit #(
   parameter int unsigned WINDOW_MAX = dwmd_pkg::WINDOW_MAX_DEF,
   parameter int unsigned COUNT_BITS = dwmd_pkg::COUNT_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   dwmd_req_if.sink                       req_bus,
   dwmd_rsp_if.source                     rsp_bus,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [dwmd_pkg::ADDR_BITS-1:0] paddr,
   input  logic [dwmd_pkg::DATA_BITS-1:0] pwdata,
   output logic [dwmd_pkg::DATA_BITS-1:0] prdata,
   output logic                           pready
);
   import dwmd_pkg::*;

   localparam int unsigned TAG_BITS = $clog2(WINDOW_MAX + 1);

   logic [WL_BITS-1:0]  window_length;
   stage_type           stage;
   logic [TAG_BITS-1:0] gap;
   logic                slot_free;
   logic                advance;
   logic                accept;

   assign req_bus.ready = !stage.valid || slot_free;
   assign accept        = req_bus.valid && req_bus.ready;

   dwmd_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .window_length (window_length)
   );

   dwmd_symtab #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_symtab (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .symbol   (req_bus.symbol),
      .new_line (req_bus.new_line),
      .advance  (advance),
      .stage    (stage),
      .gap      (gap)
   );

   dwmd_scan #(
      .WINDOW_MAX (WINDOW_MAX),
      .COUNT_BITS (COUNT_BITS)
   ) u_scan (
      .clock           (clock),
      .reset           (reset),
      .stage           (stage),
      .gap             (gap),
      .window_length   (window_length),
      .rsp_ready       (rsp_bus.ready),
      .slot_free       (slot_free),
      .advance         (advance),
      .rsp_valid       (rsp_bus.valid),
      .marker_found    (rsp_bus.marker_found),
      .marker_position (rsp_bus.marker_position)
   );

endmodule

/* hdl/dwmd_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwmd_csr
// APB register slave holding the window length.
// ----------------------------------------------------------------------------
module dwmd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [dwmd_pkg::ADDR_BITS-1:0] paddr,
   input  logic [dwmd_pkg::DATA_BITS-1:0] pwdata,
   output logic [dwmd_pkg::DATA_BITS-1:0] prdata,
   output logic                           pready,
   output logic [dwmd_pkg::WL_BITS-1:0]   window_length
);
   import dwmd_pkg::*;

   logic [WL_BITS-1:0] wl_ff;
   logic [WL_BITS-1:0] wl_in;
   logic               reg_sel;
   logic               wr_en;

   assign pready  = 1'b1;
   assign reg_sel = paddr[ADDR_LSB];
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      wl_in = wl_ff;
      if (wr_en && (reg_sel == REG_WINDOW_LENGTH)) begin
         wl_in = pwdata[WL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff <= WL_RESET;
      end else begin
         wl_ff <= wl_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_sel == REG_WINDOW_LENGTH) begin
         prdata = DATA_BITS'(wl_ff);
      end
   end

   assign window_length = wl_ff;

endmodule

/* hdl/dwmd_symtab.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwmd_symtab
// Last-seen table: one entry per byte value holding a short stamp of where
// that byte last appeared, read and rewritten on every beat, plus the
// recent-byte shift line used to confirm a table hit.
// ----------------------------------------------------------------------------
module dwmd_symtab #(
   parameter int unsigned WINDOW_MAX = dwmd_pkg::WINDOW_MAX_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [dwmd_pkg::SYM_BITS-1:0]     symbol,
   input  logic                              new_line,
   input  logic                              advance,
   output dwmd_pkg::stage_type               stage,
   output logic [$clog2(WINDOW_MAX+1)-1:0]   gap
);
   import dwmd_pkg::*;

   localparam int unsigned TAG_BITS = $clog2(WINDOW_MAX + 1);

   logic [TAG_BITS-1:0] last_tab [SYM_VALUES];
   logic [TAG_BITS-1:0] last_ff;
   logic [TAG_BITS-1:0] cur_ff;
   logic [TAG_BITS-1:0] tag_ff;
   logic [TAG_BITS-1:0] tag_in;
   logic [SYM_BITS-1:0] hist_ff [WINDOW_MAX+1];
   logic [SYM_BITS-1:0] hist_in [WINDOW_MAX+1];
   logic [SYM_BITS-1:0] tap;
   logic                nl_ff;
   logic                valid_ff;
   logic                valid_in;

   // read-first: the lookup returns the previous stamp of this byte
   always_ff @(posedge clock) begin
      if (accept) begin
         last_tab[symbol] <= tag_ff;
         last_ff          <= last_tab[symbol];
      end
   end

   always_comb begin
      hist_in[0] = symbol;
      for (int i = 1; i <= WINDOW_MAX; i++) begin
         hist_in[i] = hist_ff[i-1];
      end
   end

   always_comb begin
      tag_in   = tag_ff;
      valid_in = valid_ff;
      if (accept) begin
         tag_in   = tag_ff + 1'b1;
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         tag_ff   <= tag_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_ff  <= tag_ff;
         nl_ff   <= new_line;
         hist_ff <= hist_in;
      end
   end

   // distance back to the previous sighting, modulo the stamp range
   assign gap = cur_ff - last_ff;

   // confirm the stamp against the shift line; stale or aliased stamps miss
   always_comb begin
      tap = '0;
      for (int i = 1; i <= WINDOW_MAX; i++) begin
         if (gap == TAG_BITS'(i)) begin
            tap = hist_ff[i];
         end
      end
   end

   assign stage.valid    = valid_ff;
   assign stage.new_line = nl_ff;
   assign stage.hit      = (gap != '0) && (tap == hist_ff[0]);

endmodule

/* hdl/dwmd_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwmd_scan
// Per-line state: length of the current repeat-free run, symbol count and
// marker flag; decides the marker and holds the result register.
// ----------------------------------------------------------------------------
module dwmd_scan #(
   parameter int unsigned WINDOW_MAX = dwmd_pkg::WINDOW_MAX_DEF,
   parameter int unsigned COUNT_BITS = dwmd_pkg::COUNT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dwmd_pkg::stage_type               stage,
   input  logic [$clog2(WINDOW_MAX+1)-1:0]   gap,
   input  logic [dwmd_pkg::WL_BITS-1:0]      window_length,
   input  logic                              rsp_ready,
   output logic                              slot_free,
   output logic                              advance,
   output logic                              rsp_valid,
   output logic                              marker_found,
   output logic [dwmd_pkg::POS_BITS-1:0]     marker_position
);
   import dwmd_pkg::*;

   localparam int unsigned RUN_BITS = $clog2(WINDOW_MAX + 1);
   localparam int unsigned NB       = (RUN_BITS > WL_BITS) ? RUN_BITS : WL_BITS;
   localparam int unsigned PW       = (COUNT_BITS > POS_BITS) ? COUNT_BITS : POS_BITS;

   logic [RUN_BITS-1:0]   run_ff, run_in, run_prev;
   logic [COUNT_BITS-1:0] count_ff, count_in, count_prev;
   logic                  seen_ff, seen_in, seen_prev;
   logic                  out_valid_ff, out_valid_in;
   logic                  found_ff, found_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [NB-1:0]         n_eff;
   logic [NB-1:0]         wl_ext;
   logic [PW-1:0]         count_ext;
   logic                  dup;

   assign slot_free = !out_valid_ff || rsp_ready;
   assign advance   = stage.valid && slot_free;

   always_comb begin
      wl_ext = NB'(window_length);
      priority if (wl_ext < NB'(2)) begin
         n_eff = NB'(2);
      end else if (wl_ext > NB'(WINDOW_MAX)) begin
         n_eff = NB'(WINDOW_MAX);
      end else begin
         n_eff = wl_ext;
      end
   end

   always_comb begin
      run_prev   = stage.new_line ? '0 : run_ff;
      count_prev = stage.new_line ? '0 : count_ff;
      seen_prev  = stage.new_line ? 1'b0 : seen_ff;

      // a repeat inside the run cuts it back to the repeat distance
      dup = stage.hit && (gap <= run_prev);
      if (dup) begin
         run_in = gap;
      end else if (run_prev == RUN_BITS'(WINDOW_MAX)) begin
         run_in = run_prev;
      end else begin
         run_in = run_prev + 1'b1;
      end

      if (count_prev == {COUNT_BITS{1'b1}}) begin
         count_in = count_prev;
      end else begin
         count_in = count_prev + 1'b1;
      end

      found_in = !seen_prev && (NB'(run_in) >= n_eff);
      seen_in  = seen_prev || found_in;

      count_ext = PW'(count_in);
      if (count_ext > PW'(POS_MAX)) begin
         pos_in = POS_MAX;
      end else begin
         pos_in = count_ext[POS_BITS-1:0];
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= '0;
         count_ff     <= '0;
         seen_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            run_ff   <= run_in;
            count_ff <= count_in;
            seen_ff  <= seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         found_ff <= found_in;
         pos_ff   <= pos_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign marker_found    = found_ff;
   assign marker_position = pos_ff;

endmodule

/* hdl/dwmd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwmd_checker
// Port-level checks of the marker detector, bound to the top level.
// ----------------------------------------------------------------------------
module dwmd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_marker_found,
   input logic [dwmd_pkg::POS_BITS-1:0]  rsp_marker_position,
   input logic                           psel,
   input logic                           penable,
   input logic                           pwrite,
   input logic [dwmd_pkg::ADDR_BITS-1:0] paddr,
   input logic [dwmd_pkg::DATA_BITS-1:0] pwdata,
   input logic [dwmd_pkg::DATA_BITS-1:0] prdata,
   input logic                           pready
);
   import dwmd_pkg::*;

   // held result beat keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_marker_found)
         && $stable(rsp_marker_position))
      else $error("result beat dropped or changed while stalled");

   // an empty result register never blocks the input side
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with no result pending");

   // a marker needs at least two symbols in the line
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_marker_found |-> rsp_marker_position >= POS_BITS'(2))
      else $error("marker reported before two symbols");

   // a window length write reads back on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && (paddr[ADDR_LSB] == REG_WINDOW_LENGTH)
      |=> (paddr[ADDR_LSB] != REG_WINDOW_LENGTH)
         || (prdata == DATA_BITS'($past(pwdata[WL_BITS-1:0]))))
      else $error("window length readback mismatch");

   assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready deasserted");

endmodule

bind distinct_window_marker_detector_unit dwmd_checker u_dwmd_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_bus.ready),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_marker_found    (rsp_bus.marker_found),
   .rsp_marker_position (rsp_bus.marker_position),
   .psel                (psel),
   .penable             (penable),
   .pwrite              (pwrite),
   .paddr               (paddr),
   .pwdata              (pwdata),
   .prdata              (prdata),
   .pready              (pready)
);
